/* sv/gldu_pkg.sv */
// ----------------------------------------------------------------------------
// gldu_pkg
// Shared types and constants for the gas level duration alarm unit.
// ----------------------------------------------------------------------------
package gldu_pkg;

  localparam int unsigned BANDS     = 5;
  localparam int unsigned CNT_W     = 9;
  localparam int unsigned LIMIT_W   = 8;
  localparam int unsigned PPM_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned ROW_W     = BANDS * CNT_W;

  // band thresholds in ppm
  localparam logic [PPM_W-1:0] PPM_QUIET = 16'd15;
  localparam logic [PPM_W-1:0] PPM_B2    = 16'd24;
  localparam logic [PPM_W-1:0] PPM_B3    = 16'd50;
  localparam logic [PPM_W-1:0] PPM_B4    = 16'd100;
  localparam logic [PPM_W-1:0] PPM_B5    = 16'd300;

  localparam logic [CNT_W-1:0] CNT_MAX = 9'd511;

  // first band that drives the alarm; lower bands drive the warning
  localparam int unsigned FIRST_ALARM_BAND = 2;

  typedef logic [CNT_W-1:0]              count_t;
  typedef logic [BANDS-1:0][CNT_W-1:0]   count_row_t;
  typedef logic [LIMIT_W-1:0]            limit_t;
  typedef logic [BANDS-1:0][LIMIT_W-1:0] limit_row_t;
  typedef logic [CFG_IDX_W-1:0]          cfg_idx_t;

  // limit register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIMIT_ONE   = 3'd0,
    REG_LIMIT_TWO   = 3'd1,
    REG_LIMIT_THREE = 3'd2,
    REG_LIMIT_FOUR  = 3'd3,
    REG_LIMIT_FIVE  = 3'd4
  } reg_idx_t;

  localparam limit_row_t LIMIT_RST = {8'd1, 8'd29, 8'd89, 8'd17, 8'd35};

  // result flags, alarm_on in the lowest bit
  typedef struct packed {
    logic quiet_reset;
    logic warn_raised;
    logic alarm_raised;
    logic alarm_on;
  } flags_t;

  localparam int unsigned FLAGS_W = $bits(flags_t);

endpackage

/* sv/gas_level_duration_alarm_unit.sv */
// ----------------------------------------------------------------------------
// gas_level_duration_alarm_unit
// Gas level duration alarm: per-band sample counts with warning and alarm.
// ----------------------------------------------------------------------------
// The unit takes one ppm reading per clock while its buffer has room and
// returns one result word per reading, in the cycle after acceptance at the
// earliest. The five band counts live as one row in a small RAM that is
// read every cycle; the row written on the previous edge is forwarded past
// the RAM's registered read, so readings can follow on every cycle. A
// two-word result buffer keeps the input open while a result waits on the
// output. After reset the counts read as zero until the first reading is
// written back; no clearing pass is needed. The user must write limits
// through the cfg port (always ready) only while idle; it is not enforced.
module gas_level_duration_alarm_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] ppm_reading
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] alarm_on, [1] alarm_raised,
                                  // [2] warn_raised, [3] quiet_reset, [7:4] 0
  // limit register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import gldu_pkg::*;

  limit_row_t limit_r;
  logic       alarm_r;
  logic       row_valid_r;
  logic       fwd_r;
  count_row_t fwd_row_r;

  logic       in_acc;
  count_row_t ram_row;
  count_row_t cnt_cur;
  count_row_t cnt_nxt;
  logic       alarm_nxt;
  flags_t     flags;
  flags_t     out_flags;
  logic       buf_free;

  // limit registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LIMIT_ONE:   limit_r[0] <= cfg_data;
        REG_LIMIT_TWO:   limit_r[1] <= cfg_data;
        REG_LIMIT_THREE: limit_r[2] <= cfg_data;
        REG_LIMIT_FOUR:  limit_r[3] <= cfg_data;
        REG_LIMIT_FIVE:  limit_r[4] <= cfg_data;
        default:         ;
      endcase
    end
  end

  assign in_tready = buf_free;
  assign in_acc    = in_tvalid & in_tready;

  // count row storage, read every cycle
  gldu_ram #(
    .WIDTH (ROW_W),
    .DEPTH (1)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (in_acc),
    .waddr (1'b0),
    .wdata (cnt_nxt),
    .raddr (1'b0),
    .rdata (ram_row)
  );

  // pick the current row: zero before first write, forwarded after a write
  always_comb begin
    priority if (!row_valid_r) cnt_cur = '0;
    else if (fwd_r)            cnt_cur = fwd_row_r;
    else                       cnt_cur = ram_row;
  end

  gldu_band_update u_update (
    .ppm       (in_tdata),
    .cnt_cur   (cnt_cur),
    .limits    (limit_r),
    .alarm_cur (alarm_r),
    .cnt_nxt   (cnt_nxt),
    .alarm_nxt (alarm_nxt),
    .flags     (flags)
  );

  // control state and forwarding
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alarm_r     <= 1'b0;
      row_valid_r <= 1'b0;
      fwd_r       <= 1'b0;
    end else begin
      fwd_r <= in_acc;
      if (in_acc) begin
        alarm_r     <= alarm_nxt;
        row_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      fwd_row_r <= cnt_nxt;
    end
  end

  gldu_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_acc),
    .push_data (flags),
    .can_push  (buf_free),
    .pop_valid (out_tvalid),
    .pop_ready (out_tready),
    .pop_data  (out_flags)
  );

  assign out_tdata = {{(8 - FLAGS_W){1'b0}}, out_flags};

`ifndef NO_ASSERTIONS
  a_quiet_clears_alarm: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && flags.quiet_reset) |=> !alarm_r)
    else $error("quiet reading left the alarm active");
  a_quiet_no_raise: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && flags.quiet_reset) |-> (!flags.alarm_raised && !flags.warn_raised))
    else $error("quiet reading raised a flag");
  a_raise_sets_alarm: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && flags.alarm_raised) |=> alarm_r)
    else $error("alarm raised but flag not held");
  a_fwd_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (fwd_r && row_valid_r))
    else $error("written row not forwarded");
`endif

endmodule

/* sv/gldu_ram.sv */
// ----------------------------------------------------------------------------
// gldu_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gldu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                                            clk,
  input  logic                                            we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    waddr,
  input  logic [WIDTH-1:0]                                wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    raddr,
  output logic [WIDTH-1:0]                                rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, old data on a same-address write
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* sv/gldu_band_update.sv */
// ----------------------------------------------------------------------------
// gldu_band_update
// Classifies one reading, counts it, clears bands over limit; quiet zeroes all.
// ----------------------------------------------------------------------------
module gldu_band_update (
  input  logic [gldu_pkg::PPM_W-1:0] ppm,
  input  gldu_pkg::count_row_t       cnt_cur,
  input  gldu_pkg::limit_row_t       limits,
  input  logic                       alarm_cur,
  output gldu_pkg::count_row_t       cnt_nxt,
  output logic                       alarm_nxt,
  output gldu_pkg::flags_t           flags
);
  import gldu_pkg::*;

  logic                quiet;
  logic [BANDS-1:0]    hit;
  count_row_t          cnt_inc;
  logic [BANDS-1:0]    over;
  logic                alarm_up;
  logic                warn_up;

  // sort the reading into one band
  always_comb begin
    hit = '0;
    priority if (ppm < PPM_B2) hit[0] = 1'b1;
    else if (ppm < PPM_B3)     hit[1] = 1'b1;
    else if (ppm < PPM_B4)     hit[2] = 1'b1;
    else if (ppm < PPM_B5)     hit[3] = 1'b1;
    else                       hit[4] = 1'b1;
  end

  assign quiet = (ppm < PPM_QUIET);

  // count, then clear every band that passed its limit; a quiet reading zeroes all
  always_comb begin
    for (int i = 0; i < BANDS; i++) begin
      if (quiet) begin
        cnt_inc[i] = '0;
      end else if (hit[i] && cnt_cur[i] < CNT_MAX) begin
        cnt_inc[i] = cnt_cur[i] + 9'd1;
      end else begin
        cnt_inc[i] = cnt_cur[i];
      end
      over[i]    = cnt_inc[i] > {1'b0, limits[i]};
      cnt_nxt[i] = over[i] ? '0 : cnt_inc[i];
    end
  end

  assign alarm_up  = |over[BANDS-1:FIRST_ALARM_BAND];
  assign warn_up   = |over[FIRST_ALARM_BAND-1:0];
  assign alarm_nxt = alarm_up | (alarm_cur & ~quiet);

  assign flags.alarm_on     = alarm_nxt;
  assign flags.alarm_raised = alarm_up;
  assign flags.warn_raised  = warn_up;
  assign flags.quiet_reset  = quiet;

endmodule

/* sv/gldu_out_buf.sv */
// ----------------------------------------------------------------------------
// gldu_out_buf
// Two-word result buffer between the update logic and the output stream.
// ----------------------------------------------------------------------------
module gldu_out_buf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  gldu_pkg::flags_t push_data,
  output logic             can_push,
  output logic             pop_valid,
  input  logic             pop_ready,
  output gldu_pkg::flags_t pop_data
);
  import gldu_pkg::*;

  flags_t     ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign can_push  = (cnt_r != 2'd2);
  assign pop_valid = (cnt_r != 2'd0);
  assign pop_data  = ent_r[rd_ptr_r];
  assign pop       = pop_valid & pop_ready;

  // advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // hold result words
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> can_push)
    else $error("result buffer pushed while full");
  a_level: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result buffer level out of range");
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> cnt_r == $past(cnt_r) - 2'd1)
    else $error("result buffer level did not drop on pop");
`endif

endmodule
